FILE: src/particle_cell_list_binner_core_defines.svh
// Assertion macros shared by the binner RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef PARTICLE_CELL_LIST_BINNER_CORE_DEFINES_SVH
`define PARTICLE_CELL_LIST_BINNER_CORE_DEFINES_SVH
`ifndef SYNTH
// Plain property check, disabled during reset
`define PBIN_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pbin assertion failed");
// Implication check, disabled during reset
`define PBIN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbin implication failed");
`else
`define PBIN_ASSERT(lbl, clk, rst_n, prop)
`define PBIN_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/pbin_pkg.sv
// Shared constants, codes and types of the cell-list binner.
// No dependencies; used by every module of the block but pbin_ram.
package pbin_pkg;

    localparam int MAX_CELLS  = 4096;
    localparam int CELL_W     = $clog2(MAX_CELLS);
    localparam int SLOTS      = 16;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int LIST_W     = 1;
    localparam int NUM_LISTS  = 2;
    localparam int CNT_AW     = LIST_W + CELL_W;
    localparam int CNT_DEPTH  = NUM_LISTS * MAX_CELLS;
    localparam int ENT_AW     = CNT_AW + SLOT_W;
    localparam int ENT_DEPTH  = CNT_DEPTH * SLOTS;
    localparam int PIDX_W     = 16;
    localparam int POS_W      = 24;
    localparam int NCELL_W    = 7;
    localparam int P1_W       = 2 * NCELL_W;
    localparam int P3_W       = 3 * NCELL_W;
    localparam int ID_W       = P3_W + 1;
    localparam int DIV_STEPS  = POS_W;
    localparam int DIVC_W     = $clog2(DIV_STEPS);
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Input operations
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // Result status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Command kinds from front to back
    localparam logic [1:0] K_CLEAR  = 2'd0;
    localparam logic [1:0] K_INSERT = 2'd1;
    localparam logic [1:0] K_READ   = 2'd2;
    localparam logic [1:0] K_RANGE  = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z  = 3'd6;

    localparam logic [1:0] DIMS_3D = 2'd3;

    typedef struct packed {
        logic [1:0]         dims;
        logic [NCELL_W-1:0] cells_x;
        logic [NCELL_W-1:0] cells_y;
        logic [NCELL_W-1:0] cells_z;
        logic [POS_W-1:0]   size_x;
        logic [POS_W-1:0]   size_y;
        logic [POS_W-1:0]   size_z;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [LIST_W-1:0] list;
        logic [CELL_W-1:0] cell_no;
        logic [SLOT_W-1:0] slot;
        logic [PIDX_W-1:0] pidx;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [CELL_W-1:0] cell_id;
        logic [SLOT_W-1:0] slot;
        logic [PIDX_W-1:0] entry;
        logic [CNT_W-1:0]  count;
    } res_t;

    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] dividend;
        logic [POS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] quot;
    } div_rsp_t;

endpackage

FILE: src/pbin_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the count and entry stores.
module pbin_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: src/pbin_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on pbin_pkg; used by the front to find per-axis cell indexes.
module pbin_div (
    input  logic                clk,
    input  logic                rst_n,
    input  pbin_pkg::div_req_t  req,
    output pbin_pkg::div_rsp_t  rsp
);
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [pbin_pkg::DIVC_W-1:0]   step_reg, step_next;
    logic [pbin_pkg::POS_W-1:0]    rem_reg, rem_next;
    logic [pbin_pkg::POS_W-1:0]    quo_reg, quo_next;
    logic [pbin_pkg::POS_W-1:0]    dvs_reg, dvs_next;
    logic [pbin_pkg::POS_W:0]      shifted;
    logic [pbin_pkg::POS_W:0]      diff;

    // One shift-subtract step
    always_comb
    begin
        shifted    = {rem_reg, quo_reg[pbin_pkg::POS_W-1]};
        diff       = shifted - {1'b0, dvs_reg};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[pbin_pkg::POS_W])
            begin
                rem_next = diff[pbin_pkg::POS_W-1:0];
                quo_next = {quo_reg[pbin_pkg::POS_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[pbin_pkg::POS_W-1:0];
                quo_next = {quo_reg[pbin_pkg::POS_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == pbin_pkg::DIVC_W'(pbin_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
endmodule

FILE: src/pbin_front.sv
// Front end: accepts items, computes the linear cell id of an insert, queues commands.
// Depends on pbin_pkg and pbin_div.
module pbin_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pbin_pkg::cfg_t                cfg,
    input  logic                          hold,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    op,
    input  logic [pbin_pkg::LIST_W-1:0]   list_sel,
    input  logic [pbin_pkg::PIDX_W-1:0]   particle_index,
    input  logic [pbin_pkg::POS_W-1:0]    pos_x,
    input  logic [pbin_pkg::POS_W-1:0]    pos_y,
    input  logic [pbin_pkg::POS_W-1:0]    pos_z,
    input  logic [pbin_pkg::CELL_W-1:0]   read_cell,
    input  logic [pbin_pkg::SLOT_W-1:0]   read_slot,
    output logic                          q_push,
    input  logic                          q_full,
    output pbin_pkg::cmd_t                q_data
);
    localparam logic [2:0] F_IDLE   = 3'd0;
    localparam logic [2:0] F_DSTART = 3'd1;
    localparam logic [2:0] F_DWAIT  = 3'd2;
    localparam logic [2:0] F_MUL1   = 3'd3;
    localparam logic [2:0] F_MUL2   = 3'd4;
    localparam logic [2:0] F_SUM    = 3'd5;
    localparam logic [2:0] F_PUSH   = 3'd6;

    logic [2:0]                      state_reg, state_next;
    pbin_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [1:0]                      axis_reg, axis_next;
    logic [pbin_pkg::POS_W-1:0]      px_reg, py_reg, pz_reg;
    logic [pbin_pkg::POS_W-1:0]      px_next, py_next, pz_next;
    logic [pbin_pkg::NCELL_W-1:0]    ix_reg, iy_reg, iz_reg;
    logic [pbin_pkg::NCELL_W-1:0]    ix_next, iy_next, iz_next;
    logic [pbin_pkg::P1_W-1:0]       p1_reg, p1_next, p2_reg, p2_next;
    logic [pbin_pkg::P3_W-1:0]       p3_reg, p3_next;
    logic                            is3;
    logic [1:0]                      last_axis;
    logic [pbin_pkg::POS_W-1:0]      pos_sel, size_sel;
    logic [pbin_pkg::NCELL_W-1:0]    cells_sel;
    logic [pbin_pkg::ID_W-1:0]       id_sum;
    pbin_pkg::div_req_t              div_req;
    pbin_pkg::div_rsp_t              div_rsp;

    pbin_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign is3       = (cfg.dims == pbin_pkg::DIMS_3D);
    assign last_axis = is3 ? 2'd2 : 2'd1;

    // Per-axis operand select
    always_comb
    begin
        unique case (axis_reg)
            2'd0:
            begin
                pos_sel = px_reg; size_sel = cfg.size_x; cells_sel = cfg.cells_x;
            end
            2'd1:
            begin
                pos_sel = py_reg; size_sel = cfg.size_y; cells_sel = cfg.cells_y;
            end
            default:
            begin
                pos_sel = pz_reg; size_sel = cfg.size_z; cells_sel = cfg.cells_z;
            end
        endcase
    end

    assign id_sum = pbin_pkg::ID_W'(ix_reg) + pbin_pkg::ID_W'(p1_reg)
                  + (is3 ? pbin_pkg::ID_W'(p3_reg) : '0);

    assign full   = (state_reg != F_IDLE) || hold;
    assign q_push = (state_reg == F_PUSH) && !q_full;
    assign q_data = cmd_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        axis_next  = axis_reg;
        px_next = px_reg; py_next = py_reg; pz_next = pz_reg;
        ix_next = ix_reg; iy_next = iy_reg; iz_next = iz_reg;
        p1_next = p1_reg; p2_next = p2_reg; p3_next = p3_reg;
        div_req.start    = 1'b0;
        div_req.dividend = pos_sel;
        div_req.divisor  = size_sel;
        unique case (state_reg)
            F_IDLE:
            begin
                if (push && !hold)
                begin
                    cmd_next.list    = list_sel;
                    cmd_next.pidx    = particle_index;
                    cmd_next.cell_no = read_cell;
                    cmd_next.slot    = read_slot;
                    px_next = pos_x; py_next = pos_y; pz_next = pos_z;
                    axis_next = 2'd0;
                    priority if (op == pbin_pkg::OP_CLEAR)
                    begin
                        cmd_next.kind = pbin_pkg::K_CLEAR;
                        state_next    = F_PUSH;
                    end
                    else if (op == pbin_pkg::OP_READ)
                    begin
                        cmd_next.kind = pbin_pkg::K_READ;
                        state_next    = F_PUSH;
                    end
                    else if (op == pbin_pkg::OP_INSERT)
                    begin
                        cmd_next.kind = pbin_pkg::K_INSERT;
                        state_next    = F_DSTART;
                    end
                    else
                    begin
                        state_next = F_IDLE;
                    end
                end
            end
            F_DSTART:
            begin
                if (size_sel == '0)
                begin
                    cmd_next.kind = pbin_pkg::K_RANGE;
                    state_next    = F_PUSH;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = F_DWAIT;
                end
            end
            F_DWAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quot >= pbin_pkg::POS_W'(cells_sel))
                    begin
                        cmd_next.kind = pbin_pkg::K_RANGE;
                        state_next    = F_PUSH;
                    end
                    else
                    begin
                        unique case (axis_reg)
                            2'd0:    ix_next = div_rsp.quot[pbin_pkg::NCELL_W-1:0];
                            2'd1:    iy_next = div_rsp.quot[pbin_pkg::NCELL_W-1:0];
                            default: iz_next = div_rsp.quot[pbin_pkg::NCELL_W-1:0];
                        endcase
                        axis_next  = axis_reg + 2'd1;
                        state_next = (axis_reg == last_axis) ? F_MUL1 : F_DSTART;
                    end
                end
            end
            F_MUL1:
            begin
                p1_next    = pbin_pkg::P1_W'(iy_reg) * pbin_pkg::P1_W'(cfg.cells_x);
                p2_next    = pbin_pkg::P1_W'(cfg.cells_x) * pbin_pkg::P1_W'(cfg.cells_y);
                state_next = F_MUL2;
            end
            F_MUL2:
            begin
                p3_next    = pbin_pkg::P3_W'(iz_reg) * pbin_pkg::P3_W'(p2_reg);
                state_next = F_SUM;
            end
            F_SUM:
            begin
                cmd_next.cell_no = id_sum[pbin_pkg::CELL_W-1:0];
                if (id_sum >= pbin_pkg::ID_W'(pbin_pkg::MAX_CELLS))
                begin
                    cmd_next.kind = pbin_pkg::K_RANGE;
                end
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            axis_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        px_reg <= px_next; py_reg <= py_next; pz_reg <= pz_next;
        ix_reg <= ix_next; iy_reg <= iy_next; iz_reg <= iz_next;
        p1_reg <= p1_next; p2_reg <= p2_next; p3_reg <= p3_next;
    end
endmodule

FILE: src/pbin_cmdq.sv
// Short command queue between front and back.
// Depends on pbin_pkg and the assertion macro header.
`include "particle_cell_list_binner_core_defines.svh"
module pbin_cmdq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pbin_pkg::cmd_t  wdata,
    output logic            full,
    input  logic            pop,
    output pbin_pkg::cmd_t  rdata,
    output logic            empty
);
    pbin_pkg::cmd_t                 mem_reg [pbin_pkg::CMDQ_DEPTH];
    logic [pbin_pkg::CMDQ_PW-1:0]   wp_reg, rp_reg;
    logic [pbin_pkg::CMDQ_CW-1:0]   cnt_reg;
    logic                           do_wr, do_rd;

    assign full  = (cnt_reg == pbin_pkg::CMDQ_CW'(pbin_pkg::CMDQ_DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = push && !full;
    assign do_rd = pop && !empty;
    assign rdata = mem_reg[rp_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (do_rd)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + pbin_pkg::CMDQ_CW'(do_wr) - pbin_pkg::CMDQ_CW'(do_rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    `PBIN_ASSERT_IMP(a_no_push_full, clk, rst_n, push, !full)
    `PBIN_ASSERT(a_level_bound, clk, rst_n,
                 cnt_reg <= pbin_pkg::CMDQ_CW'(pbin_pkg::CMDQ_DEPTH))
    `PBIN_ASSERT_IMP(a_empty_consistent, clk, rst_n, empty, wp_reg == rp_reg)
endmodule

FILE: src/pbin_back.sv
// Back end: count and entry stores, clear sweeps, result register.
// Depends on pbin_pkg, pbin_ram and the assertion macro header.
`include "particle_cell_list_binner_core_defines.svh"
module pbin_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  pbin_pkg::cmd_t  q_data,
    output logic            q_pop,
    output logic            init_busy,
    output logic            empty,
    input  logic            pop,
    output pbin_pkg::res_t  res
);
    localparam logic [2:0] B_INIT = 3'd0;
    localparam logic [2:0] B_IDLE = 3'd1;
    localparam logic [2:0] B_CLR  = 3'd2;
    localparam logic [2:0] B_LOOK = 3'd3;
    localparam logic [2:0] B_CHK  = 3'd4;

    logic [2:0]                       state_reg, state_next;
    logic [pbin_pkg::CNT_AW-1:0]      sweep_reg, sweep_next;
    pbin_pkg::cmd_t                   cmd_reg, cmd_next;
    logic                             out_valid_reg, out_valid_next;
    pbin_pkg::res_t                   out_reg, out_next;

    logic                             cnt_we, cnt_re;
    logic [pbin_pkg::CNT_AW-1:0]      cnt_waddr, cnt_raddr;
    logic [pbin_pkg::CNT_W-1:0]       cnt_wdata, cnt_rdata;
    logic                             ent_we, ent_re;
    logic [pbin_pkg::ENT_AW-1:0]      ent_waddr, ent_raddr;
    logic [pbin_pkg::PIDX_W-1:0]      ent_rdata;

    pbin_ram #(.WIDTH(pbin_pkg::CNT_W), .DEPTH(pbin_pkg::CNT_DEPTH)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    pbin_ram #(.WIDTH(pbin_pkg::PIDX_W), .DEPTH(pbin_pkg::ENT_DEPTH)) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (cmd_reg.pidx),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    assign init_busy = (state_reg == B_INIT);
    assign empty     = !out_valid_reg;
    assign res       = out_reg;
    assign cnt_raddr = {cmd_reg.list, cmd_reg.cell_no};
    assign ent_raddr = {cmd_reg.list, cmd_reg.cell_no, cmd_reg.slot};
    assign ent_waddr = {cmd_reg.list, cmd_reg.cell_no, cnt_rdata[pbin_pkg::SLOT_W-1:0]};
    assign cnt_re    = (state_reg == B_LOOK);
    assign ent_re    = (state_reg == B_LOOK);

    // Command execution
    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        cmd_next       = cmd_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        q_pop          = 1'b0;
        cnt_we         = 1'b0;
        cnt_waddr      = {cmd_reg.list, cmd_reg.cell_no};
        cnt_wdata      = cnt_rdata + 1'b1;
        ent_we         = 1'b0;
        unique case (state_reg)
            B_INIT:
            begin
                cnt_we     = 1'b1;
                cnt_waddr  = sweep_reg;
                cnt_wdata  = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == '1)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_empty && !out_valid_reg)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_data;
                    unique case (q_data.kind)
                        pbin_pkg::K_CLEAR:
                        begin
                            sweep_next = {q_data.list, {pbin_pkg::CELL_W{1'b0}}};
                            state_next = B_CLR;
                        end
                        pbin_pkg::K_RANGE:
                        begin
                            out_valid_next = 1'b1;
                            out_next       = '{status: pbin_pkg::ST_RANGE, cell_id: '0,
                                               slot: '0, entry: q_data.pidx, count: '0};
                        end
                        default:
                        begin
                            state_next = B_LOOK;
                        end
                    endcase
                end
            end
            B_CLR:
            begin
                cnt_we     = 1'b1;
                cnt_waddr  = sweep_reg;
                cnt_wdata  = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg[pbin_pkg::CELL_W-1:0] == '1)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{status: pbin_pkg::ST_OK, cell_id: '0,
                                       slot: '0, entry: '0, count: '0};
                    state_next     = B_IDLE;
                end
            end
            B_LOOK:
            begin
                state_next = B_CHK;
            end
            B_CHK:
            begin
                out_valid_next = 1'b1;
                state_next     = B_IDLE;
                if (cmd_reg.kind == pbin_pkg::K_INSERT)
                begin
                    if (cnt_rdata >= pbin_pkg::CNT_W'(pbin_pkg::SLOTS))
                    begin
                        out_next = '{status: pbin_pkg::ST_FULL, cell_id: cmd_reg.cell_no,
                                     slot: '0, entry: cmd_reg.pidx, count: cnt_rdata};
                    end
                    else
                    begin
                        cnt_we   = 1'b1;
                        ent_we   = 1'b1;
                        out_next = '{status: pbin_pkg::ST_OK, cell_id: cmd_reg.cell_no,
                                     slot: cnt_rdata[pbin_pkg::SLOT_W-1:0],
                                     entry: cmd_reg.pidx, count: cnt_rdata + 1'b1};
                    end
                end
                else
                begin
                    if (pbin_pkg::CNT_W'(cmd_reg.slot) >= cnt_rdata)
                    begin
                        out_next = '{status: pbin_pkg::ST_EMPTY, cell_id: cmd_reg.cell_no,
                                     slot: cmd_reg.slot, entry: '0, count: cnt_rdata};
                    end
                    else
                    begin
                        out_next = '{status: pbin_pkg::ST_OK, cell_id: cmd_reg.cell_no,
                                     slot: cmd_reg.slot, entry: ent_rdata,
                                     count: cnt_rdata};
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_INIT;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    `PBIN_ASSERT_IMP(a_ent_wr_room, clk, rst_n, ent_we,
                     cnt_rdata < pbin_pkg::CNT_W'(pbin_pkg::SLOTS))
    `PBIN_ASSERT_IMP(a_take_when_free, clk, rst_n, q_pop, !out_valid_reg)
    `PBIN_ASSERT_IMP(a_init_once, clk, rst_n, state_reg != B_INIT,
                     ##1 state_reg != B_INIT)
    `PBIN_ASSERT_IMP(a_no_pop_busy, clk, rst_n, state_reg != B_IDLE, !q_pop)
endmodule

FILE: src/particle_cell_list_binner_core.sv
// Channel    Handshake           Payload
// input      push / full         op, list_sel, particle_index, pos_x/y/z, read_cell, read_slot
// result     pop / empty         status, cell_id, slot, entry, count
// config     cfg_wr              cfg_idx, cfg_data
//
// Insert: runs the shared serial divider once per axis, two axes or three in 3D,
// then the multiply, sum and count read-modify-write.
// Clear: zeroes the 4096 count words of one list, one per cycle through the count RAM write port.
// After reset a clearing pass zeroes all 8192 counts; full stays high meanwhile.
// A held result does not block input: the command queue keeps taking items until it fills.
//
// Top level of the cell-list binner; depends on pbin_pkg, pbin_front, pbin_cmdq, pbin_back.
module particle_cell_list_binner_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [1:0]                      op,
    input  logic [pbin_pkg::LIST_W-1:0]     list_sel,
    input  logic [pbin_pkg::PIDX_W-1:0]     particle_index,
    input  logic [pbin_pkg::POS_W-1:0]      pos_x,
    input  logic [pbin_pkg::POS_W-1:0]      pos_y,
    input  logic [pbin_pkg::POS_W-1:0]      pos_z,
    input  logic [pbin_pkg::CELL_W-1:0]     read_cell,
    input  logic [pbin_pkg::SLOT_W-1:0]     read_slot,
    output logic                            empty,
    input  logic                            pop,
    output logic [1:0]                      status,
    output logic [pbin_pkg::CELL_W-1:0]     cell_id,
    output logic [pbin_pkg::SLOT_W-1:0]     slot,
    output logic [pbin_pkg::PIDX_W-1:0]     entry,
    output logic [pbin_pkg::CNT_W-1:0]      count,
    input  logic                            cfg_wr,
    input  logic [pbin_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [pbin_pkg::CFG_DATA_W-1:0] cfg_data
);
    pbin_pkg::cfg_t  cfg_reg;
    pbin_pkg::cmd_t  fq_data, qb_data;
    pbin_pkg::res_t  res;
    logic            fq_push, q_full, q_pop, q_empty, init_busy;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dims    <= 2'd2;
            cfg_reg.cells_x <= pbin_pkg::NCELL_W'(1);
            cfg_reg.cells_y <= pbin_pkg::NCELL_W'(1);
            cfg_reg.cells_z <= pbin_pkg::NCELL_W'(1);
            cfg_reg.size_x  <= pbin_pkg::POS_W'(4096);
            cfg_reg.size_y  <= pbin_pkg::POS_W'(4096);
            cfg_reg.size_z  <= pbin_pkg::POS_W'(4096);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                pbin_pkg::CFG_DIMS:    cfg_reg.dims    <= cfg_data[1:0];
                pbin_pkg::CFG_CELLS_X: cfg_reg.cells_x <= cfg_data[pbin_pkg::NCELL_W-1:0];
                pbin_pkg::CFG_CELLS_Y: cfg_reg.cells_y <= cfg_data[pbin_pkg::NCELL_W-1:0];
                pbin_pkg::CFG_CELLS_Z: cfg_reg.cells_z <= cfg_data[pbin_pkg::NCELL_W-1:0];
                pbin_pkg::CFG_SIZE_X:  cfg_reg.size_x  <= cfg_data[pbin_pkg::POS_W-1:0];
                pbin_pkg::CFG_SIZE_Y:  cfg_reg.size_y  <= cfg_data[pbin_pkg::POS_W-1:0];
                pbin_pkg::CFG_SIZE_Z:  cfg_reg.size_z  <= cfg_data[pbin_pkg::POS_W-1:0];
                default:               cfg_reg         <= cfg_reg;
            endcase
        end
    end

    pbin_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .hold           (init_busy),
        .push           (push),
        .full           (full),
        .op             (op),
        .list_sel       (list_sel),
        .particle_index (particle_index),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .read_cell      (read_cell),
        .read_slot      (read_slot),
        .q_push         (fq_push),
        .q_full         (q_full),
        .q_data         (fq_data)
    );

    pbin_cmdq u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .wdata (fq_data),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (qb_data),
        .empty (q_empty)
    );

    pbin_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (qb_data),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign status  = res.status;
    assign cell_id = res.cell_id;
    assign slot    = res.slot;
    assign entry   = res.entry;
    assign count   = res.count;
endmodule

FILE: bench/tb_particle_cell_list_binner_core.sv
// Self-checking bench for the particle cell-list binner core.
// Depends on pbin_pkg and particle_cell_list_binner_core; a scoreboard class predicts results.
module tb_particle_cell_list_binner_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 150;

    // Predicts the binner: two lists of per-cell slot arrays plus the registers
    class bin_scoreboard;
        pbin_pkg::cfg_t  regs;
        logic [4:0]      cell_cnt [2][pbin_pkg::MAX_CELLS];
        logic [15:0]     cell_ent [2][pbin_pkg::MAX_CELLS][pbin_pkg::SLOTS];
        pbin_pkg::res_t  expected_q[$];
        int              errors;
        int              mismatches;

        function void init();
            regs = '{dims: 2'd2, cells_x: 7'd1, cells_y: 7'd1, cells_z: 7'd1,
                     size_x: 24'd4096, size_y: 24'd4096, size_z: 24'd4096};
            foreach (cell_cnt[l, c]) cell_cnt[l][c] = '0;
            errors = 0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [23:0] data);
            case (idx)
                pbin_pkg::CFG_DIMS:    regs.dims = data[1:0];
                pbin_pkg::CFG_CELLS_X: regs.cells_x = data[6:0];
                pbin_pkg::CFG_CELLS_Y: regs.cells_y = data[6:0];
                pbin_pkg::CFG_CELLS_Z: regs.cells_z = data[6:0];
                pbin_pkg::CFG_SIZE_X:  regs.size_x = data;
                pbin_pkg::CFG_SIZE_Y:  regs.size_y = data;
                pbin_pkg::CFG_SIZE_Z:  regs.size_z = data;
                default: ;
            endcase
        endfunction

        // floor(pos/size) with the grid bound; false when outside
        function bit axis_cell(longint unsigned p, longint unsigned sz, longint unsigned n,
                               output longint unsigned q);
            q = 0;
            if (sz == 0) return 0;
            q = p / sz;
            return q < n;
        endfunction

        // Accepted input item: update state and queue the expected result
        function void note_item(logic [1:0] op, logic lst, logic [15:0] pidx,
                                logic [23:0] px, logic [23:0] py, logic [23:0] pz,
                                logic [11:0] rcell, logic [3:0] rslot);
            pbin_pkg::res_t r;
            longint unsigned ix, iy, iz, id;
            bit ok;
            r = '0;
            case (op)
                pbin_pkg::OP_CLEAR: begin
                    for (int c = 0; c < pbin_pkg::MAX_CELLS; c++) cell_cnt[lst][c] = '0;
                    r.status = pbin_pkg::ST_OK;
                end
                pbin_pkg::OP_INSERT: begin
                    r.entry = pidx;
                    ok = axis_cell(px, regs.size_x, regs.cells_x, ix)
                      && axis_cell(py, regs.size_y, regs.cells_y, iy);
                    iz = 0;
                    if (ok && regs.dims == pbin_pkg::DIMS_3D)
                        ok = axis_cell(pz, regs.size_z, regs.cells_z, iz);
                    id = ix + iy * regs.cells_x;
                    if (regs.dims == pbin_pkg::DIMS_3D) id += iz * regs.cells_x * regs.cells_y;
                    if (!ok || id >= pbin_pkg::MAX_CELLS) begin
                        r.status = pbin_pkg::ST_RANGE;
                    end else if (cell_cnt[lst][id] >= pbin_pkg::SLOTS) begin
                        r.status = pbin_pkg::ST_FULL;
                        r.cell_id = pbin_pkg::CELL_W'(id);
                        r.count = cell_cnt[lst][id];
                    end else begin
                        r.status = pbin_pkg::ST_OK;
                        r.cell_id = pbin_pkg::CELL_W'(id);
                        r.slot = pbin_pkg::SLOT_W'(cell_cnt[lst][id]);
                        cell_ent[lst][id][cell_cnt[lst][id]] = pidx;
                        cell_cnt[lst][id] = 5'(cell_cnt[lst][id] + 5'd1);
                        r.count = cell_cnt[lst][id];
                    end
                end
                pbin_pkg::OP_READ: begin
                    r.cell_id = rcell;
                    r.slot = rslot;
                    r.count = cell_cnt[lst][rcell];
                    if (rslot >= cell_cnt[lst][rcell]) r.status = pbin_pkg::ST_EMPTY;
                    else begin
                        r.status = pbin_pkg::ST_OK;
                        r.entry = cell_ent[lst][rcell][rslot];
                    end
                end
                default: return;
            endcase
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void check_item(pbin_pkg::res_t got);
            pbin_pkg::res_t want;
            if (expected_q.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected result %p", got);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.cell_id !== want.cell_id ||
                got.slot !== want.slot || got.entry !== want.entry ||
                got.count !== want.count) begin
                errors++;
                if (mismatches++ < 10) $display("mismatch: expected %p got %p", want, got);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        push = 0;
    logic        full;
    logic [1:0]  op = '0;
    logic        list_sel = 0;
    logic [15:0] particle_index = '0;
    logic [23:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic [11:0] read_cell = '0;
    logic [3:0]  read_slot = '0;
    logic        empty;
    logic        pop = 0;
    logic [1:0]  status;
    logic [11:0] cell_id;
    logic [3:0]  slot;
    logic [15:0] entry;
    logic [4:0]  count;
    logic        cfg_wr = 0;
    logic [2:0]  cfg_idx = '0;
    logic [23:0] cfg_data = '0;

    bin_scoreboard sb = new();
    bit no_idle = 0;
    bit hold_req = 0;
    int hold_cnt = 0;
    logic [11:0] used_cells[$];

    particle_cell_list_binner_core uut (.*);

    always #2 clk = ~clk;

    // Result side: check accepted items, then choose pop for the next edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (pop && !empty)
                sb.check_item('{status: status, cell_id: cell_id, slot: slot,
                                entry: entry, count: count});
            if (hold_req) begin
                hold_cnt = HOLD_CYCLES;
                hold_req = 0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                pop <= 0;
            end else if (no_idle) pop <= 1;
            else pop <= ($urandom_range(99) >= 17);
        end
    end

    // One register write; the caller drops the write enable after the last one
    task automatic write_reg(logic [2:0] idx, logic [23:0] data);
        cfg_wr <= 1;
        cfg_idx <= idx;
        cfg_data <= data;
        sb.set_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic set_grid(logic [1:0] d, logic [6:0] cx, logic [6:0] cy, logic [6:0] cz,
                            logic [23:0] sx, logic [23:0] sy, logic [23:0] sz);
        write_reg(pbin_pkg::CFG_DIMS, 24'(d));
        write_reg(pbin_pkg::CFG_CELLS_X, 24'(cx));
        write_reg(pbin_pkg::CFG_CELLS_Y, 24'(cy));
        write_reg(pbin_pkg::CFG_CELLS_Z, 24'(cz));
        write_reg(pbin_pkg::CFG_SIZE_X, sx);
        write_reg(pbin_pkg::CFG_SIZE_Y, sy);
        write_reg(pbin_pkg::CFG_SIZE_Z, sz);
        cfg_wr <= 0;
    endtask

    task automatic send_item(logic [1:0] o, logic l, logic [15:0] pidx, logic [23:0] px,
                             logic [23:0] py, logic [23:0] pz, logic [11:0] rc,
                             logic [3:0] rs);
        while (!no_idle && $urandom_range(99) < 17) begin
            push <= 0;
            @(posedge clk);
        end
        push <= 1;
        op <= o;
        list_sel <= l;
        particle_index <= pidx;
        pos_x <= px;
        pos_y <= py;
        pos_z <= pz;
        read_cell <= rc;
        read_slot <= rs;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_item(o, l, pidx, px, py, pz, rc, rs);
        if (o == pbin_pkg::OP_INSERT && sb.expected_q.size() > 0 &&
            sb.expected_q[$].status != pbin_pkg::ST_RANGE)
            used_cells.insert(used_cells.size(), sb.expected_q[$].cell_id);
    endtask

    // Wait for every result, then let an item without a result run out
    task automatic drain();
        push <= 0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Coordinate that usually lands inside or just past the grid on one axis
    function automatic logic [23:0] axis_pos(longint unsigned n, longint unsigned sz);
        longint unsigned v;
        if (sz == 0 || $urandom_range(99) < 15) return 24'($urandom);
        v = longint'($urandom_range(0, 32'(n))) * sz + $urandom_range(0, 32'(sz - 1));
        if (v > 24'hFFFFFF) return 24'($urandom);
        return v[23:0];
    endfunction

    task automatic random_item();
        int pick;
        logic [11:0] rc;
        logic        lst;
        logic [15:0] pidx;
        logic [23:0] rx, ry, rz;
        logic [3:0]  rs;
        pick = $urandom_range(99);
        rc = 12'($urandom);
        lst = 1'($urandom);
        pidx = 16'($urandom);
        rx = 24'($urandom);
        ry = 24'($urandom);
        rz = 24'($urandom);
        rs = 4'($urandom);
        if (used_cells.size() > 0 && $urandom_range(99) < 70)
            rc = used_cells[$urandom_range(0, used_cells.size() - 1)];
        if (pick < 70)
            send_item(pbin_pkg::OP_INSERT, lst, pidx,
                      axis_pos(sb.regs.cells_x, sb.regs.size_x),
                      axis_pos(sb.regs.cells_y, sb.regs.size_y),
                      axis_pos(sb.regs.cells_z, sb.regs.size_z), 12'($urandom), rs);
        else if (pick < 95)
            send_item(pbin_pkg::OP_READ, lst, pidx, rx, ry, rz, rc, rs);
        else if (pick < 97)
            send_item(pbin_pkg::OP_CLEAR, lst, pidx, rx, ry, rz, 12'($urandom), rs);
        else
            send_item(OP_UNUSED, lst, pidx, rx, ry, rz, 12'($urandom), rs);
    endtask

    initial begin
        sb.init();
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: default grid of one cell, extremes, every op, fill to full
        send_item(pbin_pkg::OP_INSERT, 0, 16'h0000, 24'h0, 24'h0, 24'h0, 12'h0, 4'h0);
        send_item(pbin_pkg::OP_INSERT, 0, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                  12'hFFF, 4'hF);
        send_item(pbin_pkg::OP_READ, 0, 16'h0, 24'h0, 24'h0, 24'h0, 12'h000, 4'h0);
        send_item(pbin_pkg::OP_READ, 0, 16'h0, 24'h0, 24'h0, 24'h0, 12'h000, 4'hF);
        send_item(pbin_pkg::OP_READ, 1, 16'h0, 24'h0, 24'h0, 24'h0, 12'hFFF, 4'h0);
        send_item(OP_UNUSED, 0, 16'h0, 24'h0, 24'h0, 24'h0, 12'h0, 4'h0);
        send_item(pbin_pkg::OP_INSERT, 1, 16'hFFFF, 24'hFFF, 24'hFFF, 24'hFFFFFF,
                  12'h0, 4'h0);
        send_item(pbin_pkg::OP_CLEAR, 1, 16'h0, 24'h0, 24'h0, 24'h0, 12'h0, 4'h0);
        for (int i = 0; i < 16; i++)
            send_item(pbin_pkg::OP_INSERT, 0, 16'(16'h1000 + i), 24'(i), 24'(i), 24'h0,
                      12'h0, 4'h0);
        send_item(pbin_pkg::OP_READ, 0, 16'h0, 24'h0, 24'h0, 24'h0, 12'h000, 4'hF);
        drain();

        // Random phases over a spread of grids, extremes first
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: set_grid(2'd3, 7'd64, 7'd64, 7'd64, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
                1: set_grid(2'd2, 7'd0, 7'd1, 7'd0, 24'h0, 24'h1, 24'h0);
                2: set_grid(2'd3, 7'd127, 7'd127, 7'd127, 24'd1, 24'd1, 24'd1);
                default:
                    set_grid(2'($urandom), 7'($urandom_range(1, 4)),
                             7'($urandom_range(1, 4)), 7'($urandom_range(1, 3)),
                             24'($urandom_range(1, 24'hFFFFFF)),
                             24'($urandom_range(1, 24'h3FFF)),
                             24'($urandom_range(1, 24'hFFFF)));
            endcase
            used_cells.delete();
            no_idle = (ph == 4);
            if (ph == 5) hold_req = 1;
            for (int i = 0; i < 50; i++) random_item();
            drain();
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Guard against a hang
    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

FILE: particle_cell_list_binner_core.f
+incdir+src
src/pbin_pkg.sv
src/pbin_ram.sv
src/pbin_div.sv
src/pbin_front.sv
src/pbin_cmdq.sv
src/pbin_back.sv
src/particle_cell_list_binner_core.sv
bench/tb_particle_cell_list_binner_core.sv
